// ===== design/bpc_pkg.sv =====
// Package for the button press classifier: button count, state machine
// and action codes, configuration register indexes and reset values.
// No dependencies; used by the top level and its checker.
`default_nettype none

package bpc_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED_MASK      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULLUP_MASK       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_WINDOW_MS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PRESS_TARGET = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [NUM_BUTTONS-1:0] RST_ENABLED_MASK      = '0;
    localparam logic [NUM_BUTTONS-1:0] RST_PULLUP_MASK       = '1;
    localparam logic [7:0]             RST_SAMPLE_PERIOD     = 8'd10;
    localparam logic [15:0]            RST_LONG_PRESS_MS     = 16'd1000;
    localparam logic [15:0]            RST_FAST_WINDOW_MS    = 16'd2000;
    localparam logic [3:0]             RST_FAST_PRESS_TARGET = 4'd5;

    // Input item kinds.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT         = 3'd0,
        ST_IDLE         = 3'd1,
        ST_WAIT_LONG    = 3'd2,
        ST_WAIT_RELEASE = 3'd3,
        ST_FAST         = 3'd4,
        ST_POWERDOWN    = 3'd5
    } fsm_state_t;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_SHORT_PRESS   = 3'd1,
        ACT_SHORT_RELEASE = 3'd2,
        ACT_LONG_PRESS    = 3'd3,
        ACT_LONG_RELEASE  = 3'd4,
        ACT_FAST_PRESSES  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } scan_event_t;

    typedef struct packed {
        logic [2:0]           action;
        logic [BTN_IDX_W-1:0] button_index;
        logic [2:0]           fsm_state;
    } result_t;

endpackage

`default_nettype wire

// ===== design/button_press_classifier_unit.sv =====
// Button press classifier: timers, debounced button scan and the
// press classification state machine, with a two-entry result buffer.
// Depends on bpc_pkg.
//
// A result is registered in the output entry, or in the skid entry if m_ stalls.
// Throughput: one item per cycle while s_ready is high; the two-entry
// result buffer keeps s_ready high while one result waits on a stalled m_ side.
// Reset: synchronous on aresetn low; configuration returns to its defaults,
// the machine to init, all timers and counters to zero, result buffer empty.
`default_nettype none

module button_press_classifier_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Input items
    input  wire logic                                 s_valid,
    output      logic                                 s_ready,
    input  wire logic                                 s_func,
    input  wire logic [bpc_pkg::NUM_BUTTONS-1:0]      s_pin_levels,
    // Result items
    output      logic                                 m_valid,
    input  wire logic                                 m_ready,
    output      logic [2:0]                           m_action,
    output      logic [bpc_pkg::BTN_IDX_W-1:0]        m_button_index,
    output      logic [2:0]                           m_fsm_state
);

    localparam int NB = bpc_pkg::NUM_BUTTONS;
    localparam int BW = bpc_pkg::BTN_IDX_W;

    // Configuration registers
    logic [NB-1:0] enabled_mask_reg;
    logic [NB-1:0] pullup_mask_reg;
    logic [7:0]    sample_period_reg;
    logic [15:0]   long_press_ms_reg;
    logic [15:0]   fast_window_ms_reg;
    logic [3:0]    fast_press_target_reg;

    // Classifier state
    bpc_pkg::fsm_state_t state_reg, state_next;
    logic [NB-1:0] prev_levels_reg, prev_levels_next;
    logic [7:0]    sample_timer_reg, sample_timer_next;
    logic [15:0]   fast_timer_reg, fast_timer_next;
    logic [15:0]   hold_timer_reg, hold_timer_next;
    logic [3:0]    fast_count_reg, fast_count_next;
    logic          entry_flag_reg, entry_flag_next;
    logic [BW-1:0] held_button_reg, held_button_next;

    // Result buffer
    logic              out_valid_reg, skid_valid_reg;
    bpc_pkg::result_t  out_data_reg, skid_data_reg;
    bpc_pkg::result_t  result;

    logic s_xfer;
    logic m_xfer;

    // Scan results
    bpc_pkg::scan_event_t scan_ev;
    logic [BW-1:0]        scan_which;
    logic [NB-1:0]        scan_levels;
    logic [NB-1:0]        cur_levels;
    logic                 scan_found;

    logic [15:0] hold_eff;
    logic [3:0]  count_base;
    logic [3:0]  count_inc;

    assign s_ready = !skid_valid_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = out_valid_reg && m_ready;

    assign m_valid        = out_valid_reg;
    assign m_action       = out_data_reg.action;
    assign m_button_index = out_data_reg.button_index;
    assign m_fsm_state    = out_data_reg.fsm_state;

    assign cur_levels = s_pin_levels ^ pullup_mask_reg;

    // Priority scan, when the sample timer is zero: enabled buttons in index order up to the first change.
    always_comb begin
        scan_ev     = bpc_pkg::EV_NONE;
        scan_which  = '0;
        scan_levels = prev_levels_reg;
        scan_found  = 1'b0;
        if (sample_timer_reg == 8'd0) begin
            for (int b = 0; b < NB; b++) begin
                if (!scan_found && enabled_mask_reg[b]) begin
                    scan_levels[b] = cur_levels[b];
                    if (cur_levels[b] != prev_levels_reg[b]) begin
                        scan_found = 1'b1;
                        scan_which = BW'(b);
                        scan_ev    = cur_levels[b] ? bpc_pkg::EV_PRESS
                                                   : bpc_pkg::EV_RELEASE;
                    end
                end
            end
        end
    end

    assign hold_eff   = entry_flag_reg ? long_press_ms_reg : hold_timer_reg;
    assign count_base = (fast_timer_reg == 16'd0) ? 4'd0 : fast_count_reg;
    assign count_inc  = count_base + 4'd1;

    // Next state of the classifier for the item being transferred.
    always_comb begin
        state_next        = state_reg;
        prev_levels_next  = prev_levels_reg;
        sample_timer_next = sample_timer_reg;
        fast_timer_next   = fast_timer_reg;
        hold_timer_next   = hold_timer_reg;
        fast_count_next   = fast_count_reg;
        entry_flag_next   = entry_flag_reg;
        held_button_next  = held_button_reg;
        if (s_func == bpc_pkg::FUNC_TICK) begin
            if (sample_timer_reg != 8'd0) sample_timer_next = sample_timer_reg - 8'd1;
            if (fast_timer_reg != 16'd0)  fast_timer_next   = fast_timer_reg - 16'd1;
            if (hold_timer_reg != 16'd0)  hold_timer_next   = hold_timer_reg - 16'd1;
        end else begin
            prev_levels_next = scan_levels;
            if (sample_timer_reg == 8'd0) sample_timer_next = sample_period_reg;
            case (state_reg)
                bpc_pkg::ST_INIT: begin
                    state_next = bpc_pkg::ST_IDLE;
                end
                bpc_pkg::ST_IDLE: begin
                    if (scan_ev == bpc_pkg::EV_PRESS) begin
                        entry_flag_next  = 1'b1;
                        held_button_next = scan_which;
                        if (fast_timer_reg == 16'd0) fast_timer_next = fast_window_ms_reg;
                        if (count_inc == fast_press_target_reg) begin
                            fast_count_next = 4'd0;
                            state_next      = bpc_pkg::ST_FAST;
                        end else begin
                            fast_count_next = count_inc;
                            state_next      = bpc_pkg::ST_WAIT_LONG;
                        end
                    end
                end
                bpc_pkg::ST_WAIT_LONG: begin
                    hold_timer_next = hold_eff;
                    entry_flag_next = 1'b0;
                    if (scan_ev == bpc_pkg::EV_RELEASE) begin
                        state_next = bpc_pkg::ST_IDLE;
                    end else if (hold_eff == 16'd0) begin
                        state_next = bpc_pkg::ST_WAIT_RELEASE;
                    end
                end
                bpc_pkg::ST_WAIT_RELEASE: begin
                    if (scan_ev == bpc_pkg::EV_RELEASE) begin
                        fast_count_next = 4'd0;
                        state_next      = bpc_pkg::ST_POWERDOWN;
                    end
                end
                bpc_pkg::ST_FAST,
                bpc_pkg::ST_POWERDOWN: begin
                    state_next = bpc_pkg::ST_IDLE;
                end
                default: begin
                    state_next = bpc_pkg::ST_INIT;
                end
            endcase
        end
    end

    // Result of the item being transferred.
    always_comb begin
        result.action       = bpc_pkg::ACT_NONE;
        result.button_index = '0;
        result.fsm_state    = state_next;
        if (s_func == bpc_pkg::FUNC_POLL) begin
            case (state_reg)
                bpc_pkg::ST_IDLE: begin
                    if (scan_ev == bpc_pkg::EV_PRESS) begin
                        result.button_index = scan_which;
                        result.action = (count_inc == fast_press_target_reg)
                                      ? bpc_pkg::ACT_FAST_PRESSES
                                      : bpc_pkg::ACT_SHORT_PRESS;
                    end
                end
                bpc_pkg::ST_WAIT_LONG: begin
                    if (scan_ev == bpc_pkg::EV_RELEASE) begin
                        result.action       = bpc_pkg::ACT_SHORT_RELEASE;
                        result.button_index = scan_which;
                    end else if (hold_eff == 16'd0) begin
                        result.action       = bpc_pkg::ACT_LONG_PRESS;
                        result.button_index = held_button_reg;
                    end
                end
                bpc_pkg::ST_WAIT_RELEASE: begin
                    if (scan_ev == bpc_pkg::EV_RELEASE) begin
                        result.action       = bpc_pkg::ACT_LONG_RELEASE;
                        result.button_index = scan_which;
                    end
                end
                default: begin
                    result.action = bpc_pkg::ACT_NONE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_mask_reg      <= bpc_pkg::RST_ENABLED_MASK;
            pullup_mask_reg       <= bpc_pkg::RST_PULLUP_MASK;
            sample_period_reg     <= bpc_pkg::RST_SAMPLE_PERIOD;
            long_press_ms_reg     <= bpc_pkg::RST_LONG_PRESS_MS;
            fast_window_ms_reg    <= bpc_pkg::RST_FAST_WINDOW_MS;
            fast_press_target_reg <= bpc_pkg::RST_FAST_PRESS_TARGET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bpc_pkg::CFG_ENABLED_MASK:      enabled_mask_reg      <= cfg_wdata[NB-1:0];
                bpc_pkg::CFG_PULLUP_MASK:       pullup_mask_reg       <= cfg_wdata[NB-1:0];
                bpc_pkg::CFG_SAMPLE_PERIOD:     sample_period_reg     <= cfg_wdata[7:0];
                bpc_pkg::CFG_LONG_PRESS_MS:     long_press_ms_reg     <= cfg_wdata[15:0];
                bpc_pkg::CFG_FAST_WINDOW_MS:    fast_window_ms_reg    <= cfg_wdata[15:0];
                bpc_pkg::CFG_FAST_PRESS_TARGET: fast_press_target_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Classifier state advances on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bpc_pkg::ST_INIT;
            prev_levels_reg  <= '0;
            sample_timer_reg <= '0;
            fast_timer_reg   <= '0;
            hold_timer_reg   <= '0;
            fast_count_reg   <= '0;
            entry_flag_reg   <= 1'b0;
            held_button_reg  <= '0;
        end else if (s_xfer) begin
            state_reg        <= state_next;
            prev_levels_reg  <= prev_levels_next;
            sample_timer_reg <= sample_timer_next;
            fast_timer_reg   <= fast_timer_next;
            hold_timer_reg   <= hold_timer_next;
            fast_count_reg   <= fast_count_next;
            entry_flag_reg   <= entry_flag_next;
            held_button_reg  <= held_button_next;
        end
    end

    // Result buffer: the skid entry only fills when the output entry stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_xfer) begin
                out_valid_reg  <= skid_valid_reg || s_xfer;
                skid_valid_reg <= 1'b0;
            end else if (s_xfer) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_xfer) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (s_xfer && out_valid_reg && !m_ready) begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== design/bpc_checker.sv =====
// Port-level checker for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_unit.
`default_nettype none

module bpc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [2:0]                        m_action,
    input wire logic [bpc_pkg::BTN_IDX_W-1:0]     m_button_index,
    input wire logic [2:0]                        m_fsm_state
);

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action)
            && $stable(m_button_index) && $stable(m_fsm_state))
        else $error("result changed while stalled");

    // No result may appear right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The block never refuses input while its result side is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result buffer");

    // Each reported action leaves the machine in its matching state.
    a_action_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_action == bpc_pkg::ACT_NONE)
         || (m_action == bpc_pkg::ACT_SHORT_PRESS
                && m_fsm_state == bpc_pkg::ST_WAIT_LONG)
         || (m_action == bpc_pkg::ACT_SHORT_RELEASE
                && m_fsm_state == bpc_pkg::ST_IDLE)
         || (m_action == bpc_pkg::ACT_LONG_PRESS
                && m_fsm_state == bpc_pkg::ST_WAIT_RELEASE)
         || (m_action == bpc_pkg::ACT_LONG_RELEASE
                && m_fsm_state == bpc_pkg::ST_POWERDOWN)
         || (m_action == bpc_pkg::ACT_FAST_PRESSES
                && m_fsm_state == bpc_pkg::ST_FAST))
        else $error("action and state disagree");

    // Without an action the reported button is zero.
    a_none_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == bpc_pkg::ACT_NONE |-> m_button_index == '0)
        else $error("button index set without action");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_action       (m_action),
    .m_button_index (m_button_index),
    .m_fsm_state    (m_fsm_state)
);

`default_nettype wire
